### rtl/bru_pkg.sv
// Shared types and constants of the bit stream run length unpacker.
package bru_pkg;

    localparam int QUEUE_DEPTH_DEF = 2;

    localparam int BYTE_W  = 8;
    localparam int BITS_W  = 4;
    localparam int COUNT_W = 17;
    localparam int CFG_IDX_W = 1;

    localparam logic [7:0]         CTRL_NOP          = 8'd128;
    localparam logic [8:0]         REPEAT_BASE       = 9'd257;
    localparam logic [BITS_W-1:0]  CTRL_BITS         = 4'd8;
    localparam logic [BITS_W-1:0]  VALUE_BITS_MAX    = 4'd8;
    localparam logic [BITS_W-1:0]  VALUE_BITS_RESET  = 4'd8;
    localparam logic [COUNT_W-1:0] VALUE_COUNT_RESET = 17'd1;

    localparam logic [CFG_IDX_W-1:0] REG_VALUE_BITS  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_VALUE_COUNT = 1'b1;

    typedef struct packed {
        logic [BYTE_W-1:0] packed_byte;
        logic              end_of_stream;
    } bru_item_t;

    typedef struct packed {
        logic [7:0] value;
        logic [7:0] run_length;
        logic       final_run;
        logic       truncated;
        logic       last_of_item;
    } bru_result_t;

endpackage

### rtl/bru_front.sv
// Input side: accepts packed bytes and queues them for the bit engine.
module bru_front
    import bru_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [BYTE_W-1:0] packed_byte,
    input  logic              end_of_stream,
    output logic              item_valid,
    output bru_item_t         item,
    input  logic              item_pop
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    bru_item_t        queue_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             push;
    logic             pop;

    assign in_ready   = (count_reg != CNT_W'(DEPTH));
    assign item_valid = (count_reg != '0);
    assign item       = queue_reg[rd_ptr_reg];
    assign push       = in_valid && in_ready;
    assign pop        = item_pop && item_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            queue_reg[wr_ptr_reg] <= '{packed_byte: packed_byte, end_of_stream: end_of_stream};
        end
    end

endmodule

### rtl/bru_back.sv
// Bit engine: walks each queued byte one bit per cycle, unless a full output stage holds it, and builds the runs.
module bru_back
    import bru_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_write,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [COUNT_W-1:0]   cfg_data,
    input  logic                 item_valid,
    input  bru_item_t            item,
    output logic                 item_pop,
    output logic                 out_push,
    output bru_result_t          out_res,
    input  logic                 out_free
);

    typedef enum logic [2:0] {
        ST_BIT   = 3'b001,
        ST_CLOSE = 3'b010,
        ST_FLUSH = 3'b100
    } step_t;

    typedef enum logic [2:0] {
        PH_CONTROL = 3'b001,
        PH_LITERAL = 3'b010,
        PH_REPEAT  = 3'b100
    } phase_t;

    step_t               step_reg, step_next;
    phase_t              phase_reg, phase_next;
    logic [2:0]          bit_idx_reg, bit_idx_next;
    logic [7:0]          ctrl_shift_reg, ctrl_shift_next;
    logic [7:0]          val_shift_reg, val_shift_next;
    logic [BITS_W-1:0]   bits_reg, bits_next;
    logic [7:0]          lit_left_reg, lit_left_next;
    logic [7:0]          rep_len_reg, rep_len_next;
    logic [COUNT_W-1:0]  produced_reg, produced_next;
    logic                finished_reg, finished_next;
    logic                hold_valid_reg, hold_valid_next;
    bru_result_t         hold_reg, hold_next;
    logic [BITS_W-1:0]   value_bits_reg;
    logic [COUNT_W-1:0]  value_count_reg;

    logic [BITS_W-1:0]   vb;
    logic                count_met;
    logic                bit_in;
    logic [BITS_W-1:0]   bits_inc;
    logic [7:0]          ctrl_word;
    logic [7:0]          val_word;
    logic                ctrl_done;
    logic                val_done;
    logic                in_value_phase;
    logic [7:0]          run_len;
    logic [COUNT_W-1:0]  remaining;
    logic                clip;
    logic [7:0]          len_out;
    logic [COUNT_W-1:0]  produced_sum;
    logic [7:0]          value_masked;
    logic                hold_load;
    logic                do_flush;

    always_comb
    begin
        if (value_bits_reg == '0)
        begin
            vb = 4'd1;
        end
        else if (value_bits_reg > VALUE_BITS_MAX)
        begin
            vb = VALUE_BITS_MAX;
        end
        else
        begin
            vb = value_bits_reg;
        end
    end

    assign count_met      = (produced_reg >= value_count_reg);
    assign bit_in         = item.packed_byte[3'd7 - bit_idx_reg];
    assign bits_inc       = bits_reg + 4'd1;
    assign ctrl_word      = {ctrl_shift_reg[6:0], bit_in};
    assign val_word       = {val_shift_reg[6:0], bit_in};
    assign ctrl_done      = (bits_inc >= CTRL_BITS);
    assign val_done       = (bits_inc >= vb);
    assign in_value_phase = (phase_reg == PH_LITERAL) || (phase_reg == PH_REPEAT);
    assign run_len        = (phase_reg == PH_LITERAL) ? 8'd1 : rep_len_reg;
    assign remaining      = value_count_reg - produced_reg;
    // The run reaches the count exactly when its length covers what remains.
    assign clip           = ({9'd0, run_len} >= remaining);
    assign len_out        = clip ? remaining[7:0] : run_len;
    assign produced_sum   = clip ? value_count_reg : produced_reg + {9'd0, run_len};
    assign value_masked   = val_word & (8'hFF >> (VALUE_BITS_MAX - vb));

    always_comb
    begin
        step_next       = step_reg;
        phase_next      = phase_reg;
        bit_idx_next    = bit_idx_reg;
        ctrl_shift_next = ctrl_shift_reg;
        val_shift_next  = val_shift_reg;
        bits_next       = bits_reg;
        lit_left_next   = lit_left_reg;
        rep_len_next    = rep_len_reg;
        produced_next   = produced_reg;
        finished_next   = finished_reg;
        hold_valid_next = hold_valid_reg;
        hold_next       = hold_reg;
        hold_load       = 1'b0;
        do_flush        = 1'b0;
        item_pop        = 1'b0;
        out_push        = 1'b0;
        out_res         = hold_reg;
        out_res.last_of_item = 1'b0;

        unique case (step_reg)
            ST_BIT:
            begin
                if (item_valid)
                begin
                    if (finished_reg || count_met)
                    begin
                        // Count already reached: the rest of the byte is skipped.
                        finished_next = 1'b1;
                        bit_idx_next  = '0;
                        step_next     = ST_CLOSE;
                    end
                    else if (!(in_value_phase && val_done && hold_valid_reg && !out_free))
                    begin
                        if (in_value_phase)
                        begin
                            val_shift_next = val_word;
                            bits_next      = val_done ? '0 : bits_inc;
                            if (val_done)
                            begin
                                produced_next   = produced_sum;
                                finished_next   = finished_reg || clip;
                                hold_load       = 1'b1;
                                hold_next       = '{value: value_masked, run_length: len_out,
                                                    final_run: clip, truncated: 1'b0,
                                                    last_of_item: 1'b0};
                                hold_valid_next = 1'b1;
                                out_push        = hold_valid_reg;
                                if (phase_reg == PH_LITERAL && lit_left_reg > 8'd1)
                                begin
                                    lit_left_next = lit_left_reg - 8'd1;
                                end
                                else
                                begin
                                    if (phase_reg == PH_LITERAL)
                                    begin
                                        lit_left_next = '0;
                                    end
                                    phase_next = PH_CONTROL;
                                end
                            end
                        end
                        else
                        begin
                            phase_next      = PH_CONTROL;
                            ctrl_shift_next = ctrl_word;
                            bits_next       = ctrl_done ? '0 : bits_inc;
                            if (ctrl_done)
                            begin
                                if (ctrl_word < CTRL_NOP)
                                begin
                                    phase_next    = PH_LITERAL;
                                    lit_left_next = ctrl_word + 8'd1;
                                end
                                else if (ctrl_word > CTRL_NOP)
                                begin
                                    phase_next   = PH_REPEAT;
                                    rep_len_next = 8'(REPEAT_BASE - {1'b0, ctrl_word});
                                end
                            end
                        end
                        if (bit_idx_reg == 3'd7)
                        begin
                            bit_idx_next = '0;
                            step_next    = ST_CLOSE;
                        end
                        else
                        begin
                            bit_idx_next = bit_idx_reg + 3'd1;
                        end
                    end
                end
            end
            ST_CLOSE:
            begin
                if (count_met)
                begin
                    finished_next = 1'b1;
                end
                if (item.end_of_stream && !finished_reg && !count_met)
                begin
                    if (!hold_valid_reg || out_free)
                    begin
                        out_push        = hold_valid_reg;
                        hold_load       = 1'b1;
                        hold_next       = '{value: 8'd0, run_length: 8'd0, final_run: 1'b0,
                                            truncated: 1'b1, last_of_item: 1'b0};
                        hold_valid_next = 1'b1;
                        step_next       = ST_FLUSH;
                    end
                end
                else
                begin
                    do_flush = 1'b1;
                end
            end
            ST_FLUSH:
            begin
                do_flush = 1'b1;
            end
            default:
            begin
                step_next = ST_BIT;
            end
        endcase

        // The held result is the last one of the byte, so it leaves marked.
        if (do_flush && (!hold_valid_reg || out_free))
        begin
            out_push             = hold_valid_reg;
            out_res.last_of_item = 1'b1;
            hold_valid_next      = 1'b0;
            item_pop             = 1'b1;
            step_next            = ST_BIT;
            if (item.end_of_stream)
            begin
                phase_next      = PH_CONTROL;
                ctrl_shift_next = '0;
                val_shift_next  = '0;
                bits_next       = '0;
                lit_left_next   = '0;
                rep_len_next    = '0;
                produced_next   = '0;
                finished_next   = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg        <= ST_BIT;
            phase_reg       <= PH_CONTROL;
            bit_idx_reg     <= '0;
            ctrl_shift_reg  <= '0;
            val_shift_reg   <= '0;
            bits_reg        <= '0;
            lit_left_reg    <= '0;
            rep_len_reg     <= '0;
            produced_reg    <= '0;
            finished_reg    <= 1'b0;
            hold_valid_reg  <= 1'b0;
            value_bits_reg  <= VALUE_BITS_RESET;
            value_count_reg <= VALUE_COUNT_RESET;
        end
        else
        begin
            step_reg        <= step_next;
            phase_reg       <= phase_next;
            bit_idx_reg     <= bit_idx_next;
            ctrl_shift_reg  <= ctrl_shift_next;
            val_shift_reg   <= val_shift_next;
            bits_reg        <= bits_next;
            lit_left_reg    <= lit_left_next;
            rep_len_reg     <= rep_len_next;
            produced_reg    <= produced_next;
            finished_reg    <= finished_next;
            hold_valid_reg  <= hold_valid_next;
            if (cfg_write)
            begin
                case (cfg_index)
                    REG_VALUE_BITS:  value_bits_reg  <= cfg_data[BITS_W-1:0];
                    REG_VALUE_COUNT: value_count_reg <= cfg_data;
                    default:         value_bits_reg  <= value_bits_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        hold_reg <= hold_next;
    end

`ifndef SYNTHESIS
    a_push_has_room: assert property (@(posedge clk) disable iff (!rst_n)
        out_push |-> out_free)
        else $error("result pushed while the output stage is full");

    a_final_sets_finished: assert property (@(posedge clk) disable iff (!rst_n)
        (hold_load && hold_next.final_run) |=> finished_reg)
        else $error("final run produced without marking the stream finished");

    a_run_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (out_push && !out_res.truncated) |-> (out_res.run_length != 8'd0))
        else $error("run of length zero emitted");

    a_pop_drains_hold: assert property (@(posedge clk) disable iff (!rst_n)
        item_pop |=> !hold_valid_reg)
        else $error("byte retired while a result was still held");
`endif

endmodule

### rtl/bru_out.sv
// Output register that decouples the bit engine from the result consumer.
module bru_out
    import bru_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  bru_result_t push_res,
    output logic        push_ready,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  value,
    output logic [7:0]  run_length,
    output logic        final_run,
    output logic        truncated,
    output logic        last_of_item
);

    logic        valid_reg;
    bru_result_t res_reg;

    assign push_ready   = !valid_reg || out_ready;
    assign out_valid    = valid_reg;
    assign value        = res_reg.value;
    assign run_length   = res_reg.run_length;
    assign final_run    = res_reg.final_run;
    assign truncated    = res_reg.truncated;
    assign last_of_item = res_reg.last_of_item;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (push)
        begin
            valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            res_reg <= push_res;
        end
    end

endmodule

### rtl/bitstream_run_length_unpacker.sv
// In the bit engine each byte passes through 8 one-bit steps and a closing step.
// A byte that adds a truncation report also passes a flush step; one after the count is reached skips its rest.
// Results of a byte pass through the engine's hold register and then the output register.
// Bytes wait in a short input queue, so a new byte is taken while others are at work.
// Reset is asynchronous, active low: stream state clears, value_bits is 8, value_count is 1.
module bitstream_run_length_unpacker
    import bru_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_write,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [COUNT_W-1:0]   cfg_data,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [BYTE_W-1:0]    packed_byte,
    input  logic                 end_of_stream,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [7:0]           value,
    output logic [7:0]           run_length,
    output logic                 final_run,
    output logic                 truncated,
    output logic                 last_of_item
);

    logic        item_valid;
    bru_item_t   item;
    logic        item_pop;
    logic        res_push;
    bru_result_t res;
    logic        res_ready;

    bru_front #(
        .DEPTH (QUEUE_DEPTH)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .packed_byte   (packed_byte),
        .end_of_stream (end_of_stream),
        .item_valid    (item_valid),
        .item          (item),
        .item_pop      (item_pop)
    );

    bru_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_write  (cfg_write),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .item_valid (item_valid),
        .item       (item),
        .item_pop   (item_pop),
        .out_push   (res_push),
        .out_res    (res),
        .out_free   (res_ready)
    );

    bru_out u_out (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (res_push),
        .push_res     (res),
        .push_ready   (res_ready),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .value        (value),
        .run_length   (run_length),
        .final_run    (final_run),
        .truncated    (truncated),
        .last_of_item (last_of_item)
    );

endmodule
